// ===== src/dmg_pkg.sv =====
package dmg_pkg;

  localparam int QUBITS  = 4;
  localparam int DIM     = 1 << QUBITS;
  localparam int DEPTH   = (DIM * (DIM + 1)) / 2;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int AB_W    = (QUBITS > 1) ? QUBITS - 1 : 1;
  localparam int TRI_W   = 2 * QUBITS + 1;
  localparam int DATA_W  = 16;
  localparam int CFG_N   = 8;
  localparam int CFG_IW  = 3;
  localparam int A_W     = 34;
  localparam int B_W     = 17;
  localparam int P_W     = A_W + B_W;
  localparam int ACC_W   = 53;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] ONE_Q14  = 16'sh4000;

  typedef logic [QUBITS-1:0] qidx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_APPLY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDW,
    S_BLK,
    S_LD,
    S_LDW,
    S_MUL,
    S_ACC,
    S_RND,
    S_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx16_t;

  typedef struct packed {
    logic signed [A_W-1:0] re;
    logic signed [A_W-1:0] im;
  } cplx_a_t;

  typedef struct packed {
    logic signed [B_W-1:0] re;
    logic signed [B_W-1:0] im;
  } cplx_b_t;

  typedef struct packed {
    logic signed [P_W-1:0] rr;
    logic signed [P_W-1:0] ii;
    logic signed [P_W-1:0] ri;
    logic signed [P_W-1:0] ir;
  } prod_t;

  // lower-triangle slot of (r, c), mirrored when above the diagonal
  function automatic addr_t slot_f(qidx_t r, qidx_t c);
    qidx_t             hi;
    qidx_t             lo;
    logic [TRI_W-1:0]  tri_sum;
    hi  = (r >= c) ? r : c;
    lo  = (r >= c) ? c : r;
    tri_sum = TRI_W'(hi) * (TRI_W'(hi) + TRI_W'(1));
    return ADDR_W'((tri_sum >> 1) + TRI_W'(lo));
  endfunction

  // negate, clipping the most negative code
  function automatic logic signed [DATA_W-1:0] neg_sat_f(logic signed [DATA_W-1:0] v);
    return (v == DATA_MIN) ? DATA_MAX : -v;
  endfunction

endpackage

// ===== src/dmg_if.sv =====
interface dmg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [15:0] entry_re;
  logic signed [15:0] entry_im;
  logic [1:0]         target_qubit;
  logic [3:0]         control_mask;

  modport source (
    output valid, opcode, row_index, col_index, entry_re, entry_im,
           target_qubit, control_mask,
    input  ready
  );
  modport sink (
    input  valid, opcode, row_index, col_index, entry_re, entry_im,
           target_qubit, control_mask,
    output ready
  );
endinterface

interface dmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] read_re;
  logic signed [15:0] read_im;
  logic               gate_done;
  logic               saturated;

  modport source (
    output valid, read_re, read_im, gate_done, saturated,
    input  ready
  );
  modport sink (
    input  valid, read_re, read_im, gate_done, saturated,
    output ready
  );
endinterface

// ===== src/dmg_cmul.sv =====
module dmg_cmul (
  input  logic             clk_i,
  input  logic             en_i,
  input  dmg_pkg::cplx_a_t a_i,
  input  dmg_pkg::cplx_b_t b_i,
  output dmg_pkg::prod_t   prod_o
);
  import dmg_pkg::*;

  logic signed [P_W-1:0] a_re, a_im, b_re, b_im;
  prod_t                 prod_q;

  assign a_re = P_W'($signed(a_i.re));
  assign a_im = P_W'($signed(a_i.im));
  assign b_re = P_W'($signed(b_i.re));
  assign b_im = P_W'($signed(b_i.im));

  // register the four partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q.rr <= a_re * b_re;
      prod_q.ii <= a_im * b_im;
      prod_q.ri <= a_re * b_im;
      prod_q.ir <= a_im * b_re;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== src/density_matrix_one_qubit_gate.sv =====
// channel | dir | handshake       | word
// in_i    | in  | valid / ready   | opcode, row/col index, entry, target, control mask
// out_o   | out | valid / ready   | read_re, read_im, gate_done, saturated
// cfg     | in  | cfg_we_i        | gate register index and 16 bit value
//
// Entry write: stored from the accepted word. Entry read: the memory word is
// registered, staged in S_RDW and moved to the output register in S_RESP.
// Gate apply: DIM/2*(DIM/2+1)/2 blocks of 2x2 are visited; a block is skipped unless
// its rows or columns meet the control mask, else it is loaded, run through the one
// shared complex multiplier (row only, column only or both sides), rounded and stored.
// Reset clears control state and sets the identity gate; the density store is not cleared.
// A result waiting in the output register does not hold off entry writes.
module density_matrix_one_qubit_gate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dmg_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [dmg_pkg::DATA_W-1:0]  cfg_data_i,
  dmg_in_if.sink                      in_i,
  dmg_out_if.source                   out_o
);
  import dmg_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } sat_t;

  function automatic sat_t round_sat_f(logic signed [ACC_W-1:0] v, logic wide);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W:0] q;
    sat_t                  r;
    if (wide) begin
      t = (ACC_W+1)'(v) + ((ACC_W+1)'(1) <<< 27);
      q = t >>> 28;
    end else begin
      t = (ACC_W+1)'(v) + ((ACC_W+1)'(1) <<< 13);
      q = t >>> 14;
    end
    if (q > (ACC_W+1)'(DATA_MAX)) begin
      r.val = DATA_MAX; r.clip = 1'b1;
    end else if (q < (ACC_W+1)'(DATA_MIN)) begin
      r.val = DATA_MIN; r.clip = 1'b1;
    end else begin
      r.val = DATA_W'(q); r.clip = 1'b0;
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic signed [DATA_W-1:0] g_q [CFG_N];
  logic [1:0]        tq_q;
  qidx_t             cm_q;
  logic [AB_W-1:0]   a_q, b_q;
  logic [1:0]        cnt_q, el_q;
  logic              term_q, phase_q, flag_q;
  logic              pend_q, rd_conj_q;
  logic [1:0]        pend_idx_q;
  cplx16_t           s_q [4];
  cplx16_t           d_q [4];
  logic signed [A_W-1:0]   t_re_q [4];
  logic signed [A_W-1:0]   t_im_q [4];
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [DATA_W-1:0] res_re_q, res_im_q, out_re_q, out_im_q;
  logic              res_done_q, res_sat_q, out_done_q, out_sat_q, out_valid_q;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] mem_rdata_q;
  logic        mem_we, mem_re;
  addr_t       mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  logic      accept, out_free, in_ok, in_tq_ok, in_conj;
  qidx_t     in_row, in_col, in_tbit;
  qidx_t     tbit, low, ax, bx, r0, r1, c0, c1, ent_r, ent_c;
  logic      rin, cin, both, row_only, blk_last;
  logic [1:0] wr_e, ent_e, gi;
  logic      ent_conj, wr_flag;
  addr_t     ent_addr;
  cplx16_t   wd;
  logic signed [DATA_W-1:0] w_im, cap_re, cap_raw, cap_im;
  cplx_a_t   op_a;
  cplx_b_t   op_b;
  prod_t     prod;
  logic signed [ACC_W-1:0] sum_re, sum_im, acc_re_n, acc_im_n, src_re, src_im;
  sat_t      rnd_re, rnd_im;

  // decode the incoming word
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_row   = qidx_t'(in_i.row_index);
  assign in_col   = qidx_t'(in_i.col_index);
  assign in_ok    = (int'(in_i.row_index) < DIM) && (int'(in_i.col_index) < DIM);
  assign in_tq_ok = int'(in_i.target_qubit) < QUBITS;
  assign in_conj  = in_row < in_col;
  assign in_tbit  = qidx_t'(1) << in_i.target_qubit;

  // block coordinates: insert the target bit into a and b
  assign tbit = qidx_t'(1) << tq_q;
  assign low  = tbit - qidx_t'(1);
  assign ax   = qidx_t'(a_q);
  assign bx   = qidx_t'(b_q);
  assign r0   = ((ax & ~low) << 1) | (ax & low);
  assign c0   = ((bx & ~low) << 1) | (bx & low);
  assign r1   = r0 | tbit;
  assign c1   = c0 | tbit;
  assign rin  = (r0 & cm_q) == cm_q;
  assign cin  = (c0 & cm_q) == cm_q;
  assign both = rin && cin;
  assign row_only = rin && !cin;
  assign blk_last = (b_q == a_q) && (a_q == AB_W'(DIM / 2 - 1));

  // entry of the block: loads in order 00,01,10,11; stores 00,11,10,01
  assign wr_e     = {cnt_q[1] ^ cnt_q[0], cnt_q[0]};
  assign ent_e    = (state_q == S_WR) ? wr_e : cnt_q;
  assign ent_r    = ent_e[1] ? r1 : r0;
  assign ent_c    = ent_e[0] ? c1 : c0;
  assign ent_conj = ent_r < ent_c;
  assign ent_addr = slot_f(ent_r, ent_c);

  assign wd      = d_q[wr_e];
  assign w_im    = ent_conj ? neg_sat_f(wd.im) : wd.im;
  assign wr_flag = ent_conj && (wd.im == DATA_MIN);

  // returned word, conjugated when mirrored
  assign cap_re  = mem_rdata_q[31:16];
  assign cap_raw = mem_rdata_q[15:0];
  assign cap_im  = rd_conj_q ? neg_sat_f(cap_raw) : cap_raw;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ent_addr;
    mem_raddr = ent_addr;
    mem_wdata = {wd.re, w_im};
    if (state_q == S_IDLE && accept && in_ok) begin
      if (opcode_e'(in_i.opcode) == OP_WRITE) begin
        mem_we    = 1'b1;
        mem_waddr = slot_f(in_row, in_col);
        mem_wdata = {in_i.entry_re,
                     in_conj ? neg_sat_f(in_i.entry_im) : in_i.entry_im};
      end
      if (opcode_e'(in_i.opcode) == OP_READ) begin
        mem_re    = 1'b1;
        mem_raddr = slot_f(in_row, in_col);
      end
    end
    if (state_q == S_LD) mem_re = 1'b1;
    if (state_q == S_WR) mem_we = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem_q[mem_raddr];
  end

  // multiplier operands: T = M*S first, then T*M^dagger or S*M^dagger
  always_comb begin
    if (!phase_q) begin
      gi      = {el_q[1], term_q};
      op_a.re = A_W'($signed(s_q[{term_q, el_q[0]}].re));
      op_a.im = A_W'($signed(s_q[{term_q, el_q[0]}].im));
      op_b.re = B_W'($signed(g_q[{gi, 1'b0}]));
      op_b.im = B_W'($signed(g_q[{gi, 1'b1}]));
    end else begin
      gi      = {el_q[0], term_q};
      op_b.re = B_W'($signed(g_q[{gi, 1'b0}]));
      op_b.im = -B_W'($signed(g_q[{gi, 1'b1}]));
      if (both) begin
        op_a.re = t_re_q[{el_q[1], term_q}];
        op_a.im = t_im_q[{el_q[1], term_q}];
      end else begin
        op_a.re = A_W'($signed(s_q[{el_q[1], term_q}].re));
        op_a.im = A_W'($signed(s_q[{el_q[1], term_q}].im));
      end
    end
  end

  dmg_cmul u_cmul (
    .clk_i  (clk_i),
    .en_i   (state_q == S_MUL),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // accumulate and round
  assign sum_re   = ACC_W'($signed(prod.rr)) - ACC_W'($signed(prod.ii));
  assign sum_im   = ACC_W'($signed(prod.ri)) + ACC_W'($signed(prod.ir));
  assign acc_re_n = term_q ? acc_re_q + sum_re : sum_re;
  assign acc_im_n = term_q ? acc_im_q + sum_im : sum_im;
  assign src_re   = row_only ? ACC_W'(t_re_q[el_q]) : acc_re_q;
  assign src_im   = row_only ? ACC_W'(t_im_q[el_q]) : acc_im_q;
  assign rnd_re   = round_sat_f(src_re, both);
  assign rnd_im   = round_sat_f(src_im, both);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_e'(in_i.opcode))
            OP_READ:  state_d = in_ok ? S_RDW : S_RESP;
            OP_APPLY: state_d = in_tq_ok ? S_BLK : S_RESP;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_RDW: state_d = S_RESP;
      S_BLK: begin
        if (rin || cin)   state_d = S_LD;
        else if (blk_last) state_d = S_RESP;
      end
      S_LD:  if (cnt_q == 2'd3) state_d = S_LDW;
      S_LDW: state_d = S_MUL;
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (!term_q)                       state_d = S_MUL;
        else if (phase_q)                  state_d = S_RND;
        else if (el_q == 2'd3 && !cin)     state_d = S_RND;
        else                               state_d = S_MUL;
      end
      S_RND: begin
        if (el_q == 2'd3)  state_d = S_WR;
        else if (row_only) state_d = S_RND;
        else               state_d = S_MUL;
      end
      S_WR: begin
        if (cnt_q == 2'd3) state_d = blk_last ? S_RESP : S_BLK;
      end
      S_RESP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int n = 0; n < CFG_N; n++) g_q[n] <= '0;
      g_q[0]      <= ONE_Q14;
      g_q[6]      <= ONE_Q14;
      tq_q        <= '0;
      cm_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      cnt_q       <= '0;
      el_q        <= '0;
      term_q      <= 1'b0;
      phase_q     <= 1'b0;
      flag_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == S_LD);
      if (cfg_we_i) g_q[cfg_index_i] <= cfg_data_i;

      // flag any clip in the sweep
      if (pend_q && rd_conj_q && cap_raw == DATA_MIN) flag_q <= 1'b1;
      if (state_q == S_RND && (rnd_re.clip || rnd_im.clip)) flag_q <= 1'b1;
      if (state_q == S_WR && wr_flag) flag_q <= 1'b1;

      unique case (state_q)
        S_IDLE: begin
          if (accept && opcode_e'(in_i.opcode) == OP_APPLY) begin
            tq_q   <= in_i.target_qubit;
            cm_q   <= qidx_t'(in_i.control_mask) & ~in_tbit;
            a_q    <= '0;
            b_q    <= '0;
            flag_q <= 1'b0;
          end
        end
        S_BLK: begin
          cnt_q <= '0;
          if (!(rin || cin) && !blk_last) begin
            if (b_q == a_q) begin
              a_q <= a_q + AB_W'(1);
              b_q <= '0;
            end else begin
              b_q <= b_q + AB_W'(1);
            end
          end
        end
        S_LD: cnt_q <= cnt_q + 2'd1;
        S_LDW: begin
          el_q    <= '0;
          term_q  <= 1'b0;
          phase_q <= !rin;
        end
        S_ACC: begin
          term_q <= !term_q;
          if (term_q && !phase_q) begin
            el_q <= el_q + 2'd1;
            if (el_q == 2'd3) phase_q <= 1'b1;
          end
        end
        S_RND: el_q <= el_q + 2'd1;
        S_WR: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3 && !blk_last) begin
            if (b_q == a_q) begin
              a_q <= a_q + AB_W'(1);
              b_q <= '0;
            end else begin
              b_q <= b_q + AB_W'(1);
            end
          end
        end
        default: ;
      endcase

      // output register handshake
      if (state_q == S_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= cnt_q;
    if (state_q == S_IDLE) rd_conj_q <= in_conj;
    if (state_q == S_LD)   rd_conj_q <= ent_conj;
    if (pend_q) s_q[pend_idx_q] <= '{re: cap_re, im: cap_im};

    if (state_q == S_ACC) begin
      acc_re_q <= acc_re_n;
      acc_im_q <= acc_im_n;
      if (term_q && !phase_q) begin
        t_re_q[el_q] <= A_W'(acc_re_n);
        t_im_q[el_q] <= A_W'(acc_im_n);
      end
    end
    if (state_q == S_RND) d_q[el_q] <= '{re: rnd_re.val, im: rnd_im.val};

    // stage the result word
    if (state_q == S_IDLE && accept) begin
      res_re_q   <= '0;
      res_im_q   <= '0;
      res_done_q <= (opcode_e'(in_i.opcode) == OP_APPLY);
      res_sat_q  <= 1'b0;
    end
    if (state_q == S_RDW) begin
      res_re_q <= cap_re;
      res_im_q <= cap_im;
    end
    if (state_q == S_BLK) res_sat_q <= flag_q;
    if (state_q == S_WR)  res_sat_q <= flag_q | wr_flag;

    if (state_q == S_RESP && out_free) begin
      out_re_q   <= res_re_q;
      out_im_q   <= res_im_q;
      out_done_q <= res_done_q;
      out_sat_q  <= res_sat_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_re   = out_re_q;
  assign out_o.read_im   = out_im_q;
  assign out_o.gate_done = out_done_q;
  assign out_o.saturated = out_sat_q;

endmodule

// ===== bench/density_matrix_one_qubit_gate_tb.sv =====
`timescale 1ns / 1ps

module density_matrix_one_qubit_gate_tb;
  import dmg_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES = 2000;

  typedef enum logic [CFG_IW-1:0] {
    G00_RE, G00_IM, G01_RE, G01_IM, G10_RE, G10_IM, G11_RE, G11_IM
  } gate_reg_e;

  typedef struct {
    longint re;
    longint im;
  } cval_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               done;
    logic               sat;
  } resp_t;

  // Predicts the density store and the response words of the block
  class density_scoreboard;
    logic signed [15:0] st_re[DEPTH];
    logic signed [15:0] st_im[DEPTH];
    logic signed [15:0] gate_regs[CFG_N];
    resp_t              pending_q[$];
    int                 errors;
    bit                 clip;

    function new();
      errors = 0;
      foreach (st_re[i]) begin
        st_re[i] = '0;
        st_im[i] = '0;
      end
      foreach (gate_regs[i]) gate_regs[i] = '0;
      gate_regs[G00_RE] = ONE_Q14;
      gate_regs[G11_RE] = ONE_Q14;
    endfunction

    function void set_reg(int idx, logic signed [15:0] v);
      gate_regs[idx] = v;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function longint clamp(longint v);
      if (v > 32767) begin
        clip = 1;
        return 32767;
      end
      if (v < -32768) begin
        clip = 1;
        return -32768;
      end
      return v;
    endfunction

    function int tri_slot(int r, int c);
      int hi;
      int lo;
      hi = (r >= c) ? r : c;
      lo = (r >= c) ? c : r;
      return hi * (hi + 1) / 2 + lo;
    endfunction

    function cval_t load(int r, int c);
      cval_t v;
      int    k;
      k = tri_slot(r, c);
      v.re = st_re[k];
      v.im = st_im[k];
      if (r < c) v.im = clamp(-v.im);
      return v;
    endfunction

    function void store(int r, int c, cval_t v);
      int k;
      k = tri_slot(r, c);
      st_re[k] = 16'(v.re);
      st_im[k] = (r >= c) ? 16'(v.im) : 16'(clamp(-v.im));
    endfunction

    function cval_t cmul(cval_t a, cval_t b);
      cval_t p;
      p.re = a.re * b.re - a.im * b.im;
      p.im = a.re * b.im + a.im * b.re;
      return p;
    endfunction

    function cval_t conj(cval_t a);
      a.im = -a.im;
      return a;
    endfunction

    // Round to nearest with ties up, which is an arithmetic shift of v + half
    function longint rnd(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function void sweep(int tq, int mask);
      cval_t g[2][2];
      cval_t s[2][2];
      cval_t d[2][2];
      cval_t acc;
      cval_t t;
      int    tbit, low, cm, r0, r1, c0, c1, sh;
      bit    rin, cin;
      for (int i = 0; i < 4; i++) begin
        g[i >> 1][i & 1].re = gate_regs[2 * i];
        g[i >> 1][i & 1].im = gate_regs[2 * i + 1];
      end
      tbit = 1 << tq;
      low = tbit - 1;
      cm = mask & (DIM - 1) & ~tbit;
      for (int a = 0; a < DIM / 2; a++) begin
        r0 = ((a & ~low) << 1) | (a & low);
        r1 = r0 | tbit;
        rin = (r0 & cm) == cm;
        for (int b = 0; b <= a; b++) begin
          c0 = ((b & ~low) << 1) | (b & low);
          c1 = c0 | tbit;
          cin = (c0 & cm) == cm;
          if (!rin && !cin) continue;
          s[0][0] = load(r0, c0);
          s[0][1] = load(r0, c1);
          s[1][0] = load(r1, c0);
          s[1][1] = load(r1, c1);
          for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
              acc.re = 0;
              acc.im = 0;
              if (rin && cin) begin
                for (int k = 0; k < 2; k++)
                  for (int l = 0; l < 2; l++) begin
                    t = cmul(cmul(g[i][k], conj(g[j][l])), s[k][l]);
                    acc.re += t.re;
                    acc.im += t.im;
                  end
                sh = 28;
              end else if (rin) begin
                for (int k = 0; k < 2; k++) begin
                  t = cmul(g[i][k], s[k][j]);
                  acc.re += t.re;
                  acc.im += t.im;
                end
                sh = 14;
              end else begin
                for (int l = 0; l < 2; l++) begin
                  t = cmul(s[i][l], conj(g[j][l]));
                  acc.re += t.re;
                  acc.im += t.im;
                end
                sh = 14;
              end
              d[i][j].re = clamp(rnd(acc.re, sh));
              d[i][j].im = clamp(rnd(acc.im, sh));
            end
          end
          store(r0, c0, d[0][0]);
          store(r1, c1, d[1][1]);
          store(r1, c0, d[1][0]);
          store(r0, c1, d[0][1]);
        end
      end
    endfunction

    // Note an accepted input word and queue the response it causes
    function void note(opcode_e op, int r, int c, logic signed [15:0] ere,
                       logic signed [15:0] eim, int tq, int mask);
      cval_t v;
      resp_t e;
      e = '{re: '0, im: '0, done: 1'b0, sat: 1'b0};
      case (op)
        OP_WRITE: begin
          v.re = ere;
          v.im = eim;
          store(r, c, v);
        end
        OP_READ: begin
          v = load(r, c);
          e.re = 16'(v.re);
          e.im = 16'(v.im);
          pending_q.push_back(e);
        end
        OP_APPLY: begin
          clip = 0;
          if (tq < QUBITS) sweep(tq, mask);
          e.done = 1'b1;
          e.sat = clip;
          pending_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    // Check one response word against the oldest prediction
    function void check(resp_t act);
      resp_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected response re=%0d im=%0d done=%0b sat=%0b",
                 $time, act.re, act.im, act.done, act.sat);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (act.re !== e.re || act.im !== e.im || act.done !== e.done ||
          act.sat !== e.sat) begin
        $display("%0t: mismatch expected re=%0d im=%0d done=%0b sat=%0b",
                 $time, e.re, e.im, e.done, e.sat);
        $display("%0t:          actual   re=%0d im=%0d done=%0b sat=%0b",
                 $time, act.re, act.im, act.done, act.sat);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  int                n_in;
  int                cycles;
  bit                sender_eager;
  density_scoreboard sb;

  dmg_in_if  in_if ();
  dmg_out_if out_if ();

  density_matrix_one_qubit_gate u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return '0;
      3: return 16'($urandom_range(0, 1024)) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one input word and hold it until it is taken
  task automatic send(opcode_e op, int r, int c, logic signed [15:0] ere,
                      logic signed [15:0] eim, int tq, int mask);
    int gap;
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.opcode = op;
    in_if.row_index = 4'(r);
    in_if.col_index = 4'(c);
    in_if.entry_re = ere;
    in_if.entry_im = eim;
    in_if.target_qubit = 2'(tq);
    in_if.control_mask = 4'(mask);
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(gate_reg_e idx, logic signed [15:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Drop valid and wait until every response is back and the block is quiet
  task automatic settle();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_gate(int kind);
    logic signed [15:0] v[CFG_N];
    case (kind)
      0: foreach (v[i]) v[i] = DATA_MAX;
      1: foreach (v[i]) v[i] = DATA_MIN;
      2: v = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0,
               16'sd11585, 16'sd0, -16'sd11585, 16'sd0};
      3: v = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384,
               16'sd0, 16'sd16384, 16'sd0, 16'sd0};
      default: foreach (v[i]) v[i] = pick_value();
    endcase
    for (int i = 0; i < CFG_N; i++) write_reg(gate_reg_e'(i), v[i]);
  endtask

  task automatic random_item();
    int p;
    int r;
    int c;
    p = $urandom_range(0, 99);
    r = $urandom_range(0, DIM - 1);
    c = $urandom_range(0, DIM - 1);
    if (p < 45)
      send(OP_WRITE, r, c, pick_value(), pick_value(), 0, 0);
    else if (p < 85)
      send(OP_READ, r, c, 16'($urandom), 16'($urandom),
           $urandom_range(0, 3), $urandom_range(0, 15));
    else if (p < 97)
      send(OP_APPLY, r, c, 16'($urandom), 16'($urandom),
           $urandom_range(0, 3), $urandom_range(0, 15));
    else
      send(OP_NONE, r, c, 16'($urandom), 16'($urandom),
           $urandom_range(0, 3), $urandom_range(0, 15));
  endtask

  // Note accepted input words and check response words
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.note(opcode_e'(in_if.opcode), in_if.row_index, in_if.col_index,
              in_if.entry_re, in_if.entry_im, in_if.target_qubit,
              in_if.control_mask);
      n_in++;
    end
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check('{re: out_if.read_re, im: out_if.read_im,
                 done: out_if.gate_done, sat: out_if.saturated});
  end

  // Drive ready with random stalls, one long hold-off and stall-free stretches
  initial begin
    bit held;
    bit eager;
    int gap;
    held = 0;
    eager = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && n_in >= 400) begin
        held = 1;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if ($urandom_range(0, 199) == 0) eager = !eager;
      gap = eager ? 0 : pick_gap();
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Bound the run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    n_in = 0;
    sender_eager = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_WRITE;
    in_if.row_index = '0;
    in_if.col_index = '0;
    in_if.entry_re = '0;
    in_if.entry_im = '0;
    in_if.target_qubit = '0;
    in_if.control_mask = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill every stored entry so that no sweep or read sees unwritten data
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c <= r; c++)
        send(OP_WRITE, r, c, pick_value() >>> 2, pick_value() >>> 2, 0, 0);

    // Directed words under the reset gate
    send(OP_WRITE, 5, 2, DATA_MAX, DATA_MIN, 0, 0);
    send(OP_READ, 5, 2, '0, '0, 0, 0);
    send(OP_READ, 2, 5, '0, '0, 0, 0);
    send(OP_WRITE, 3, 9, DATA_MIN, DATA_MIN, 0, 0);
    send(OP_READ, 9, 3, '0, '0, 0, 0);
    send(OP_READ, 3, 9, '0, '0, 0, 0);
    send(OP_WRITE, 15, 15, DATA_MAX, DATA_MAX, 0, 0);
    send(OP_READ, 15, 15, '0, '0, 0, 0);
    send(OP_WRITE, 0, 0, 16'sd8192, 16'sd0, 0, 0);
    send(OP_READ, 0, 0, '0, '0, 0, 0);
    send(OP_NONE, 1, 1, '0, '0, 0, 0);
    send(OP_APPLY, 0, 0, '0, '0, 0, 4'b0000);
    send(OP_APPLY, 0, 0, '0, '0, 3, 4'b1111);
    send(OP_READ, 15, 0, '0, '0, 0, 0);
    settle();
    load_gate(2);
    send(OP_APPLY, 0, 0, '0, '0, 0, 4'b0000);
    send(OP_APPLY, 0, 0, '0, '0, 1, 4'b0100);
    send(OP_APPLY, 0, 0, '0, '0, 2, 4'b1011);
    send(OP_READ, 12, 13, '0, '0, 0, 0);
    send(OP_READ, 6, 6, '0, '0, 0, 0);
    settle();
    load_gate(0);
    send(OP_APPLY, 0, 0, '0, '0, 3, 4'b0001);
    send(OP_READ, 7, 1, '0, '0, 0, 0);
    settle();
    load_gate(1);
    send(OP_APPLY, 0, 0, '0, '0, 0, 4'b0110);
    send(OP_READ, 1, 14, '0, '0, 0, 0);
    settle();

    // Random phases over several gate settings
    for (int ph = 0; ph < 6; ph++) begin
      load_gate((ph < 4) ? ph + 2 : 4);
      if (ph == 5) load_gate(0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) sender_eager = !sender_eager;
        random_item();
      end
      settle();
    end

    // Wait out the tail
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dmg_pkg.sv
src/dmg_if.sv
src/dmg_cmul.sv
src/density_matrix_one_qubit_gate.sv
bench/density_matrix_one_qubit_gate_tb.sv
